@@ hw/rtl/bba_pkg.sv @@
// Shared widths, codes and defaults for the buddy block allocator.
package bba_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int POOL_ORDER_RST = 10;

  localparam int ADDR_W = 10;
  localparam int ORD_W  = 4;
  localparam int STAT_W = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVAL = 2'd2;

endpackage

@@ hw/rtl/bba_ram.sv @@
// Single-write, single-read synchronous RAM with registered read data.
module bba_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] wa,
  input  logic [DATA_BITS-1:0] wd,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] ra,
  output logic [DATA_BITS-1:0] rd
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // Write port, read port with held data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ hw/rtl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: request sequencer, unit memories, result register.
//
//  channel   | signals                         | beat contents
//  ----------+---------------------------------+------------------------------------------
//  request   | s_tvalid s_tready s_tdata s_tuser | kind, block_order, unit_addr
//  result    | m_tvalid m_tready m_tdata         | result_addr, merged_order, status
//  config    | cfg_we cfg_wdata                  | pool_order
//
// One request at a time. Allocate: scan the free lists in turn, remove the block found,
// then split it down to the requested order; free: check the block, merge with free buddies,
// then close and push. A final step loads the result register.
// The single read port of the unit memory paces these steps.
// After reset and after every pool_order write a clearing pass runs through the free-bit
// memory; no request is taken meanwhile.
// A result held on a stalled output only blocks the request after the next one.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [ORD_W-1:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // block_order [3:0], unit_addr [13:4], zero [15:14]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // result_addr [9:0], merged_order [13:10], status [15:14]
);

  localparam int AW = MAX_ORDER;
  localparam int LW = AW + 1;
  localparam int OW = $clog2(MAX_ORDER + 2);
  localparam int HW = $clog2(MAX_ORDER + 1);
  localparam int WW = 2 * LW + OW;
  localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};
  localparam logic [OW-1:0] MAX_ORD = OW'(MAX_ORDER);
  localparam logic [OW-1:0] POOL_RST =
    (POOL_ORDER_RST > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(POOL_ORDER_RST);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001, S_INIT  = 16'h0002, S_IDLE  = 16'h0004, S_SCAN  = 16'h0008,
    S_FCHK  = 16'h0010, S_FLOOP = 16'h0020, S_FBUD  = 16'h0040, S_RM    = 16'h0080,
    S_RMP   = 16'h0100, S_RMN   = 16'h0200, S_RMN2  = 16'h0400, S_RMEND = 16'h0800,
    S_SPLIT = 16'h1000, S_PUSH  = 16'h2000, S_PUSHH = 16'h4000, S_EMIT  = 16'h8000
  } state_t;

  state_t          state;
  logic [OW-1:0]   pool_order;
  logic [OW-1:0]   lvl;
  logic [OW-1:0]   req_ord;
  logic            kind_r;
  logic [AW-1:0]   a;
  logic [AW-1:0]   tgt;
  logic [AW-1:0]   px;
  logic [LW-1:0]   ph;
  logic [LW-1:0]   pn;
  logic [LW-1:0]   pp;
  logic [AW:0]     clr_idx;
  logic [LW-1:0]   head [MAX_ORDER+1];
  logic [ADDR_W-1:0] res_addr;
  logic [ORD_W-1:0]  res_ord;
  logic [STAT_W-1:0] res_stat;

  // Memory ports
  logic            re;
  logic [AW-1:0]   ra;
  logic            we_l;
  logic            we_f;
  logic [AW-1:0]   wa;
  logic [WW-1:0]   wdl;
  logic            wdf;
  logic [WW-1:0]   rdl;
  logic            rdf;

  logic [LW-1:0]   rd_nx;
  logic [LW-1:0]   rd_pv;
  logic [OW-1:0]   rd_mk;
  assign rd_nx = rdl[WW-1 -: LW];
  assign rd_pv = rdl[OW +: LW];
  assign rd_mk = rdl[OW-1:0];

  // Request fields
  logic            accept;
  logic            emit_go;
  logic [OW-1:0]   ord_in;
  logic [AW-1:0]   addr_in;
  logic            misalign;
  logic            oob;
  logic [LW-1:0]   head_l;
  logic [AW-1:0]   bud;
  logic [OW-1:0]   cfg_clamped;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign emit_go  = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign ord_in   = OW'(s_tdata[3:0]);
  assign addr_in  = AW'(s_tdata[13:4]);
  assign misalign = (addr_in & ((AW'(1) << ord_in) - AW'(1))) != '0;
  assign oob      = ((AW+2)'(addr_in) + ((AW+2)'(1) << ord_in)) > ((AW+2)'(1) << pool_order);
  assign head_l   = (lvl <= MAX_ORD) ? head[lvl[HW-1:0]] : NIL;
  assign bud      = a ^ (AW'(1) << lvl);
  assign cfg_clamped = (OW'(cfg_wdata) > MAX_ORD) ? MAX_ORD : OW'(cfg_wdata);

  bba_ram #(.ADDR_BITS(AW), .DATA_BITS(WW)) u_link (
    .clk(clk), .we(we_l), .wa(wa), .wd(wdl), .re(re), .ra(ra), .rd(rdl)
  );

  bba_ram #(.ADDR_BITS(AW), .DATA_BITS(1)) u_free (
    .clk(clk), .we(we_f), .wa(wa), .wd(wdf), .re(re), .ra(ra), .rd(rdf)
  );

  // Drive memory reads and writes per state
  always_comb begin
    re   = 1'b0;
    ra   = '0;
    we_l = 1'b0;
    we_f = 1'b0;
    wa   = '0;
    wdl  = '0;
    wdf  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we_f = 1'b1;
        wa   = clr_idx[AW-1:0];
      end
      S_INIT: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wdl  = {NIL, NIL, pool_order};
        wdf  = 1'b1;
      end
      S_IDLE: begin
        re = accept;
        ra = addr_in;
      end
      S_SCAN: begin
        re = (lvl <= pool_order) && (head_l != NIL);
        ra = head_l[AW-1:0];
      end
      S_FLOOP: begin
        re = (lvl < pool_order);
        ra = bud;
      end
      S_RM: begin
        re = (rd_pv != NIL);
        ra = rd_pv[AW-1:0];
      end
      S_RMP: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wa   = pp[AW-1:0];
        wdl  = {pn, rd_pv, rd_mk};
        wdf  = 1'b1;
      end
      S_RMN: begin
        re = (pn != NIL);
        ra = pn[AW-1:0];
      end
      S_RMN2: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wa   = pn[AW-1:0];
        wdl  = {rd_nx, pp, rd_mk};
        wdf  = 1'b1;
      end
      S_RMEND: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wa   = tgt;
        wdl  = {pn, pp, (kind_r == KIND_ALLOC) ? req_ord : lvl};
      end
      S_PUSH: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wa   = px;
        wdl  = {head_l, NIL, lvl};
        wdf  = 1'b1;
        re   = (head_l != NIL);
        ra   = head_l[AW-1:0];
      end
      S_PUSHH: begin
        we_l = 1'b1;
        we_f = 1'b1;
        wa   = ph[AW-1:0];
        wdl  = {rd_nx, LW'(px), rd_mk};
        wdf  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequence one request through scan, removal, split, merge and push
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pool_order <= POOL_RST;
      clr_idx    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (AW+1)'((2 ** AW) - 1)) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          for (int i = 0; i <= MAX_ORDER; i++) begin
            head[i] <= (OW'(i) == pool_order) ? '0 : NIL;
          end
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            kind_r  <= s_tuser;
            req_ord <= ord_in;
            lvl     <= ord_in;
            a       <= addr_in;
            if (ord_in > pool_order) begin
              res_stat <= STAT_INVAL;
              state    <= S_EMIT;
            end else if (s_tuser == KIND_ALLOC) begin
              state <= S_SCAN;
            end else if (misalign || oob) begin
              res_stat <= STAT_INVAL;
              state    <= S_EMIT;
            end else begin
              state <= S_FCHK;
            end
          end
        end
        S_SCAN: begin
          if (lvl > pool_order) begin
            res_stat <= STAT_NOMEM;
            state    <= S_EMIT;
          end else if (head_l == NIL) begin
            lvl <= lvl + 1'b1;
          end else begin
            a     <= head_l[AW-1:0];
            tgt   <= head_l[AW-1:0];
            state <= S_RM;
          end
        end
        S_FCHK: begin
          if (rdf || (rd_mk != req_ord)) begin
            res_stat <= STAT_INVAL;
            state    <= S_EMIT;
          end else begin
            state <= S_FLOOP;
          end
        end
        S_FLOOP: begin
          if (lvl < pool_order) begin
            tgt   <= bud;
            state <= S_FBUD;
          end else begin
            px    <= a;
            state <= S_PUSH;
          end
        end
        S_FBUD: begin
          if (!rdf || (rd_mk != lvl)) begin
            px    <= a;
            state <= S_PUSH;
          end else begin
            state <= S_RM;
          end
        end
        S_RM: begin
          pn <= rd_nx;
          pp <= rd_pv;
          if (rd_pv == NIL) begin
            head[lvl[HW-1:0]] <= rd_nx;
            state <= S_RMN;
          end else begin
            state <= S_RMP;
          end
        end
        S_RMP: begin
          state <= S_RMN;
        end
        S_RMN: begin
          state <= (pn != NIL) ? S_RMN2 : S_RMEND;
        end
        S_RMN2: begin
          state <= S_RMEND;
        end
        S_RMEND: begin
          if (kind_r == KIND_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            if (tgt < a) begin
              a <= tgt;
            end
            lvl   <= lvl + 1'b1;
            state <= S_FLOOP;
          end
        end
        S_SPLIT: begin
          if (lvl > req_ord) begin
            lvl   <= lvl - 1'b1;
            px    <= a | (AW'(1) << (lvl - 1'b1));
            state <= S_PUSH;
          end else begin
            res_stat <= STAT_OK;
            res_addr <= ADDR_W'(a);
            res_ord  <= ORD_W'(req_ord);
            state    <= S_EMIT;
          end
        end
        S_PUSH: begin
          head[lvl[HW-1:0]] <= LW'(px);
          ph <= head_l;
          if (head_l != NIL) begin
            state <= S_PUSHH;
          end else if (kind_r == KIND_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            res_stat <= STAT_OK;
            res_addr <= ADDR_W'(px);
            res_ord  <= ORD_W'(lvl);
            state    <= S_EMIT;
          end
        end
        S_PUSHH: begin
          if (kind_r == KIND_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            res_stat <= STAT_OK;
            res_addr <= ADDR_W'(px);
            res_ord  <= ORD_W'(lvl);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (res_stat == STAT_OK) begin
              m_tdata <= {res_stat, res_ord, res_addr};
            end else begin
              m_tdata <= {res_stat, {ORD_W{1'b0}}, {ADDR_W{1'b0}}};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Pool reinit on register write
      if (cfg_we) begin
        pool_order <= cfg_clamped;
        clr_idx    <= '0;
        state      <= S_CLEAR;
      end
    end
  end

  // A pool_order write always starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> state == S_CLEAR) else $error("no clear after pool_order write");

  // No memory writes while waiting for a request
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we_l && !we_f) else $error("memory write while idle");

  // Reads and writes never target the same unit in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    re && we_l |-> ra != wa) else $error("read and write of same unit");

  // Successful results never exceed the pool order
  a_ok_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15:14] == STAT_OK |-> OW'(m_tdata[13:10]) <= pool_order)
    else $error("merged order above pool order");

endmodule
